@@ design/ets_pkg.sv @@
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants, token codes and types of the expression token scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int MAX_WORD_LENGTH = 32;
    localparam int VALUE_BITS      = 31;
    localparam int WORD_LEN_BITS   = 8;
    localparam int KIND_BITS       = 4;
    localparam int INT_FIELD_BITS  = 31;

    // result queue
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // token kinds
    localparam logic [KIND_BITS-1:0] K_EOF     = 4'd0;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 4'd1;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 4'd2;
    localparam logic [KIND_BITS-1:0] K_STAR    = 4'd3;
    localparam logic [KIND_BITS-1:0] K_SLASH   = 4'd4;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 4'd5;
    localparam logic [KIND_BITS-1:0] K_INT     = 4'd6;
    localparam logic [KIND_BITS-1:0] K_PRINT   = 4'd7;
    localparam logic [KIND_BITS-1:0] K_BADCHAR = 4'd8;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN = 4'd9;
    localparam logic [KIND_BITS-1:0] K_TOOLONG = 4'd10;

    // scanner modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_INT  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;
    localparam logic [1:0] MODE_HALT = 2'd3;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [2:0] KW_LEN = 3'd5;

    typedef struct packed {
        logic [KIND_BITS-1:0]      token_kind;
        logic [INT_FIELD_BITS-1:0] num_value;
        logic                      int_overflow;
        logic [7:0]                bad_byte;
        logic                      last_result;
    } t_token;

    // characters of the keyword "print"
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h70;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

endpackage

@@ design/ets_if.sv @@
// ----------------------------------------------------------------------------
// ets_if
// Valid/ready channels of the scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface ets_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ets_token_if
    import ets_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_BITS-1:0]      token_kind;
    logic [INT_FIELD_BITS-1:0] num_value;
    logic                      int_overflow;
    logic [7:0]                bad_byte;
    logic                      last_result;

    modport source (output valid, output token_kind, output num_value,
                    output int_overflow, output bad_byte, output last_result,
                    input ready);
    modport sink   (input valid, input token_kind, input num_value,
                    input int_overflow, input bad_byte, input last_result,
                    output ready);
endinterface

@@ design/ets_queue.sv @@
// ----------------------------------------------------------------------------
// ets_queue
// Small result queue: takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module ets_queue
    import ets_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr0,
    input  logic   i_wr1,
    input  t_token i_tok0,
    input  t_token i_tok1,
    output logic   o_room2,
    output logic   o_valid,
    output t_token o_tok,
    input  logic   i_pop
);

    t_token                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count, n_count;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr1;
    logic                      pop;
    logic [1:0]                n_wr;

    assign o_room2 = (r_count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign n_wr    = {1'b0, i_wr0} + {1'b0, i_wr1};

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_BITS'(n_wr);
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_BITS'(pop);
        n_count  = r_count + (QUEUE_PTR_BITS+1)'(n_wr) - (QUEUE_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // second token only ever follows a first one
    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wr_ptr] <= i_tok0;
        end
        if (i_wr0 && i_wr1) begin
            r_mem[wr_ptr1] <= i_tok1;
        end
    end

endmodule

@@ design/expression_token_scanner_core.sv @@
// ----------------------------------------------------------------------------
// expression_token_scanner_core
// Byte-at-a-time lexical scanner for integers, operators and the print keyword.
// ----------------------------------------------------------------------------
// One source byte (or end-of-input request) is taken per clock while the
// four-entry result queue has room for two tokens; the scanner state is
// updated in the same cycle and the up to two resulting tokens are written
// into the queue registers before they appear on the output. While the sink is
// ready, the output drains one token per cycle, so a stream averages one byte
// per cycle unless many bytes each give two tokens, in which case the output
// port sets the pace. After any error token the scanner swallows all further
// input without result until reset.
module expression_token_scanner_core
    import ets_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ets_byte_if.sink        i_src,
    ets_token_if.source     o_tok
);

    logic [1:0]               r_mode, n_mode;
    logic [VALUE_BITS-1:0]    r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic [2:0]               r_kw_pos, n_kw_pos;
    logic                     r_kw_ok, n_kw_ok;
    logic [WORD_LEN_BITS-1:0] r_len, n_len;

    logic       room2;
    logic       accept;
    logic [7:0] c;
    logic       eoi;
    logic       wr0, wr1;
    t_token     tok0, tok1, tok_q;
    logic       q_valid;

    logic [VALUE_BITS+3:0] prod;
    logic                  prod_ovf;
    logic                  kw_hit;
    logic                  word_ch;

    assign c       = i_src.in_byte;
    assign eoi     = i_src.end_of_input;
    assign accept  = i_src.valid && room2;
    assign i_src.ready = room2;
    assign word_ch = is_alpha(c) || is_digit(c) || (c == CH_UNDER);

    // acc*10 + digit, overflow when it leaves the value range
    assign prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                + (VALUE_BITS+4)'(c - CH_ZERO);
    assign prod_ovf = (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0);

    assign kw_hit = r_kw_ok && (r_kw_pos < KW_LEN) && (c == kw_char(r_kw_pos));

    always_comb begin
        logic   go_start;
        logic   have0;
        logic   have_s;
        t_token ts;

        n_mode   = r_mode;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_kw_pos = r_kw_pos;
        n_kw_ok  = r_kw_ok;
        n_len    = r_len;
        tok0     = '0;
        tok1     = '0;
        ts       = '0;
        go_start = 1'b0;
        have0    = 1'b0;
        have_s   = 1'b0;

        case (r_mode)
            MODE_INT: begin
                if (!eoi && is_digit(c)) begin
                    if (prod_ovf) begin
                        n_acc = '1;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = prod[VALUE_BITS-1:0];
                    end
                end else begin
                    tok0.token_kind   = K_INT;
                    tok0.num_value    = INT_FIELD_BITS'(r_acc);
                    tok0.int_overflow = r_sat;
                    have0    = 1'b1;
                    n_mode   = MODE_IDLE;
                    n_acc    = '0;
                    n_sat    = 1'b0;
                    go_start = 1'b1;
                end
            end
            MODE_WORD: begin
                if (!eoi && word_ch) begin
                    if (r_len >= WORD_LEN_BITS'(MAX_WORD_LENGTH)) begin
                        tok0.token_kind = K_TOOLONG;
                        have0  = 1'b1;
                        n_mode = MODE_HALT;
                    end else begin
                        if (kw_hit) begin
                            n_kw_pos = r_kw_pos + 3'd1;
                        end else begin
                            n_kw_ok = 1'b0;
                        end
                        n_len = r_len + 1'b1;
                    end
                end else if (r_kw_ok && (r_kw_pos == KW_LEN)) begin
                    tok0.token_kind = K_PRINT;
                    have0    = 1'b1;
                    n_mode   = MODE_IDLE;
                    n_kw_pos = 3'd0;
                    n_kw_ok  = 1'b1;
                    n_len    = '0;
                    go_start = 1'b1;
                end else begin
                    // unknown word: the ending byte is dropped
                    tok0.token_kind = K_UNKNOWN;
                    have0  = 1'b1;
                    n_mode = MODE_HALT;
                end
            end
            MODE_IDLE: begin
                go_start = 1'b1;
            end
            default: begin
            end
        endcase

        if (go_start) begin
            if (eoi) begin
                ts.token_kind = K_EOF;
                have_s = 1'b1;
            end else if (is_space(c)) begin
                have_s = 1'b0;
            end else if (c == CH_PLUS) begin
                ts.token_kind = K_PLUS;
                have_s = 1'b1;
            end else if (c == CH_MINUS) begin
                ts.token_kind = K_MINUS;
                have_s = 1'b1;
            end else if (c == CH_STAR) begin
                ts.token_kind = K_STAR;
                have_s = 1'b1;
            end else if (c == CH_SLASH) begin
                ts.token_kind = K_SLASH;
                have_s = 1'b1;
            end else if (c == CH_SEMI) begin
                ts.token_kind = K_SEMI;
                have_s = 1'b1;
            end else if (is_digit(c)) begin
                n_mode = MODE_INT;
                n_acc  = VALUE_BITS'(c - CH_ZERO);
                n_sat  = 1'b0;
            end else if (is_alpha(c) || (c == CH_UNDER)) begin
                // first word character is matched against position zero
                n_mode   = MODE_WORD;
                n_kw_ok  = (c == kw_char(3'd0));
                n_kw_pos = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
                n_len    = WORD_LEN_BITS'(1);
            end else begin
                ts.token_kind = K_BADCHAR;
                ts.bad_byte   = c;
                have_s = 1'b1;
                n_mode = MODE_HALT;
            end
        end

        if (have0) begin
            if (have_s) begin
                tok1 = ts;
                tok1.last_result = 1'b1;
            end else begin
                tok0.last_result = 1'b1;
            end
        end else begin
            tok0 = ts;
            tok0.last_result = 1'b1;
        end

        wr0 = accept && (have0 || have_s);
        wr1 = accept && have0 && have_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_acc    <= '0;
            r_sat    <= 1'b0;
            r_kw_pos <= 3'd0;
            r_kw_ok  <= 1'b1;
            r_len    <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_sat    <= n_sat;
            r_kw_pos <= n_kw_pos;
            r_kw_ok  <= n_kw_ok;
            r_len    <= n_len;
        end
    end

    ets_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (wr0),
        .i_wr1   (wr1),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_room2 (room2),
        .o_valid (q_valid),
        .o_tok   (tok_q),
        .i_pop   (o_tok.ready)
    );

    assign o_tok.valid        = q_valid;
    assign o_tok.token_kind   = tok_q.token_kind;
    assign o_tok.num_value    = tok_q.num_value;
    assign o_tok.int_overflow = tok_q.int_overflow;
    assign o_tok.bad_byte     = tok_q.bad_byte;
    assign o_tok.last_result  = tok_q.last_result;

endmodule
